FILE: src/pwmc_pkg.sv
// Shared types and constants for the PWM period and duty calculator.
package pwmc_pkg;

    // Field and datapath widths
    localparam int unsigned FIELD_W  = 17;   // reload, compare, frequency
    localparam int unsigned PERIOD_W = 18;   // reload + 1 may reach 2**17
    localparam int unsigned DUTY_W   = 7;
    localparam int unsigned DIV_W    = 36;   // dividend and quotient
    localparam int unsigned DVSR_W   = 20;   // divisor (frequency up to 1 MHz)
    localparam int unsigned CNT_W    = $clog2(DIV_W + 1);

    // Action codes
    localparam logic [1:0] ACT_SET_FREQ = 2'd0;
    localparam logic [1:0] ACT_SET_DUTY = 2'd1;
    localparam logic [1:0] ACT_QUERY    = 2'd2;

    // Reset and fixed constants
    localparam logic [FIELD_W-1:0] RELOAD_RST  = 17'd999;
    localparam logic [FIELD_W-1:0] COMPARE_RST = 17'd500;
    localparam logic [FIELD_W-1:0] FIELD_MAX   = 17'h1FFFF;
    localparam logic [DUTY_W-1:0]  DUTY_FULL   = 7'd100;
    localparam logic [31:0]        DUTY_LIMIT  = 32'd100;
    localparam logic [DVSR_W-1:0]  PCT_DIVISOR = 20'd100;
    localparam logic [DIV_W-1:0]   PCT_ROUND   = 36'd50;
    localparam logic [PERIOD_W-1:0] PCT_SCALE  = 18'd100;

    // Input word
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] value;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic               accepted;
        logic [FIELD_W-1:0] reload_out;
        logic [FIELD_W-1:0] compare_out;
        logic [FIELD_W-1:0] frequency_out;
        logic [DUTY_W-1:0]  duty_out;
    } out_word_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: src/pwmc_div.sv
// Restoring serial divider, one quotient bit per cycle.
module pwmc_div
    import pwmc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [DIV_W-1:0]  quo_reg;

    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;
    logic              fits;
    logic [DVSR_W-1:0] rem_next;

    // One trial subtraction
    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, dvsr_reg};
        fits     = (trial >= {1'b0, dvsr_reg});
        rem_next = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
            // one-cycle pulse after the last quotient bit
            done_reg <= !req.start && busy_reg && (cnt_reg == CNT_W'(1));
        end
    end

    // Datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: src/pwm_period_duty_calculator_core.sv
// PWM period and duty calculator: sequencer, multiplier and shared divider.
//
// Holds a PWM reload value (period minus one, in ticks) and a compare value,
// 999 and 500 after reset (1 kHz at 50% with a 1 MHz tick). A set-frequency
// word (10..100000 Hz by default) recomputes the rounded period and rescales
// the compare so the duty ratio is kept; a set-duty word (0..100%) sets the
// compare from the period; a query, or action code 3, changes nothing. Out of
// range requests are rejected with accepted low and leave the state alone.
// Each word returns one result with the registers and the rounded current
// frequency and duty. One word is processed at a time: s_ready is high only
// while the sequencer is idle. All divisions run on one restoring divider at
// one quotient bit per cycle. A set-duty or query word needs one division when
// the compare ends at zero or at the full period (e.g. set-duty at 0 or 100%),
// two for a query at partial duty and three for set-duty at partial duty, and
// a set-frequency with a rescaled compare needs up to four, so the number of
// divisions sets the time a word takes. The result sits in an output
// register, so the next word may be accepted while it waits for m_ready.
module pwm_period_duty_calculator_core
    import pwmc_pkg::*;
#(
    parameter int unsigned TICK_RATE_HZ = 1000000,
    parameter int unsigned MIN_FREQ_HZ  = 10,
    parameter int unsigned MAX_FREQ_HZ  = 100000
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam logic [DIV_W-1:0] TICK_DW = DIV_W'(TICK_RATE_HZ);
    localparam logic [31:0]      MIN_F   = 32'(MIN_FREQ_HZ);
    localparam logic [31:0]      MAX_F   = 32'(MAX_FREQ_HZ);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_PER_DIV  = 10'b0000000010,
        ST_CCR_MUL  = 10'b0000000100,
        ST_CCR_DIV  = 10'b0000001000,
        ST_SD_MUL   = 10'b0000010000,
        ST_SD_DIV   = 10'b0000100000,
        ST_FREQ_DIV = 10'b0001000000,
        ST_DUTY_MUL = 10'b0010000000,
        ST_DUTY_DIV = 10'b0100000000,
        ST_DONE     = 10'b1000000000
    } state_t;

    state_t             state_reg;
    logic               div_go_reg;
    logic [FIELD_W-1:0] reload_reg;
    logic [FIELD_W-1:0] compare_reg;
    logic [FIELD_W-1:0] pn_reg;
    logic [31:0]        val_reg;
    logic               ok_reg;
    logic [FIELD_W-1:0] freq_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic [DIV_W-1:0]   mul_reg;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    state_t             state_next;
    logic               div_go_next;
    logic [FIELD_W-1:0] reload_next;
    logic [FIELD_W-1:0] compare_next;
    logic [FIELD_W-1:0] pn_next;
    logic [31:0]        val_next;
    logic               ok_next;
    logic [FIELD_W-1:0] freq_next;
    logic [DUTY_W-1:0]  duty_next;
    logic               m_valid_next;
    out_word_t          m_data_next;

    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] mul_a;
    logic [PERIOD_W-1:0] mul_b;
    logic [FIELD_W-1:0]  q_sat;
    logic                q_zero;
    logic                cmp_full;
    logic                freq_ok;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    pwmc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Period, quotient saturation and range checks
    always_comb begin
        period   = {1'b0, reload_reg} + PERIOD_W'(1);
        q_zero   = (div_rsp.quotient == '0);
        q_sat    = (div_rsp.quotient > DIV_W'(FIELD_MAX)) ? FIELD_MAX
                                                         : div_rsp.quotient[FIELD_W-1:0];
        cmp_full = ({1'b0, compare_reg} >= period);
        freq_ok  = (s_data.value >= MIN_F) && (s_data.value <= MAX_F);
    end

    // Multiplier operand select
    always_comb begin
        unique case (state_reg)
            ST_CCR_MUL: begin
                mul_a = {1'b0, compare_reg};
                mul_b = {1'b0, pn_reg};
            end
            ST_SD_MUL: begin
                mul_a = period;
                mul_b = PERIOD_W'(val_reg[DUTY_W-1:0]);
            end
            ST_DUTY_MUL: begin
                mul_a = {1'b0, compare_reg};
                mul_b = PCT_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operand select; launch on entering a divide state
    always_comb begin
        div_req.start = div_go_reg;
        unique case (state_reg)
            ST_PER_DIV: begin
                div_req.dividend = TICK_DW + DIV_W'(val_reg[DVSR_W-1:1]);
                div_req.divisor  = val_reg[DVSR_W-1:0];
            end
            ST_CCR_DIV: begin
                div_req.dividend = mul_reg + DIV_W'(period[PERIOD_W-1:1]);
                div_req.divisor  = DVSR_W'(period);
            end
            ST_SD_DIV: begin
                div_req.dividend = mul_reg + PCT_ROUND;
                div_req.divisor  = PCT_DIVISOR;
            end
            ST_FREQ_DIV: begin
                div_req.dividend = TICK_DW + DIV_W'(period[PERIOD_W-1:1]);
                div_req.divisor  = DVSR_W'(period);
            end
            ST_DUTY_DIV: begin
                div_req.dividend = mul_reg + DIV_W'(period[PERIOD_W-1:1]);
                div_req.divisor  = DVSR_W'(period);
            end
            default: begin
                div_req.dividend = '0;
                div_req.divisor  = '0;
            end
        endcase
    end

    // Shared multiplier, registered
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_CCR_MUL) || (state_reg == ST_SD_MUL)
            || (state_reg == ST_DUTY_MUL)) begin
            mul_reg <= mul_a * mul_b;
        end
    end

    // Sequencer next state
    always_comb begin
        state_next   = state_reg;
        div_go_next  = 1'b0;
        reload_next  = reload_reg;
        compare_next = compare_reg;
        pn_next      = pn_reg;
        val_next     = val_reg;
        ok_next      = ok_reg;
        freq_next    = freq_reg;
        duty_next    = duty_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next    = s_data.value;
                    ok_next     = 1'b1;
                    state_next  = ST_FREQ_DIV;
                    div_go_next = 1'b1;
                    if (s_data.action == ACT_SET_FREQ) begin
                        if (freq_ok) begin
                            state_next = ST_PER_DIV;
                        end else begin
                            ok_next = 1'b0;
                        end
                    end else if (s_data.action == ACT_SET_DUTY) begin
                        if (s_data.value > DUTY_LIMIT) begin
                            ok_next = 1'b0;
                        end else if (s_data.value == '0) begin
                            compare_next = '0;
                        end else if (s_data.value == DUTY_LIMIT) begin
                            compare_next = period[FIELD_W-1:0];
                        end else begin
                            state_next  = ST_SD_MUL;
                            div_go_next = 1'b0;
                        end
                    end
                end
            end

            ST_PER_DIV: begin
                if (div_rsp.done) begin
                    state_next  = ST_FREQ_DIV;
                    div_go_next = 1'b1;
                    pn_next     = q_sat;
                    if (q_zero) begin
                        ok_next = 1'b0;
                    end else if (compare_reg == '0) begin
                        reload_next = q_sat - FIELD_W'(1);
                    end else if (cmp_full) begin
                        reload_next  = q_sat - FIELD_W'(1);
                        compare_next = q_sat;
                    end else begin
                        state_next  = ST_CCR_MUL;
                        div_go_next = 1'b0;
                    end
                end
            end

            ST_CCR_MUL: begin
                state_next  = ST_CCR_DIV;
                div_go_next = 1'b1;
            end

            ST_CCR_DIV: begin
                if (div_rsp.done) begin
                    compare_next = div_rsp.quotient[FIELD_W-1:0];
                    reload_next  = pn_reg - FIELD_W'(1);
                    state_next   = ST_FREQ_DIV;
                    div_go_next  = 1'b1;
                end
            end

            ST_SD_MUL: begin
                state_next  = ST_SD_DIV;
                div_go_next = 1'b1;
            end

            ST_SD_DIV: begin
                if (div_rsp.done) begin
                    compare_next = div_rsp.quotient[FIELD_W-1:0];
                    state_next   = ST_FREQ_DIV;
                    div_go_next  = 1'b1;
                end
            end

            ST_FREQ_DIV: begin
                if (div_rsp.done) begin
                    freq_next = q_sat;
                    if (compare_reg == '0) begin
                        duty_next  = '0;
                        state_next = ST_DONE;
                    end else if (cmp_full) begin
                        duty_next  = DUTY_FULL;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DUTY_MUL;
                    end
                end
            end

            ST_DUTY_MUL: begin
                state_next  = ST_DUTY_DIV;
                div_go_next = 1'b1;
            end

            ST_DUTY_DIV: begin
                if (div_rsp.done) begin
                    duty_next  = (div_rsp.quotient > DIV_W'(DUTY_FULL))
                                 ? DUTY_FULL : div_rsp.quotient[DUTY_W-1:0];
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next.accepted      = ok_reg;
                    m_data_next.reload_out    = reload_reg;
                    m_data_next.compare_out   = compare_reg;
                    m_data_next.frequency_out = freq_reg;
                    m_data_next.duty_out      = duty_reg;
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_go_reg  <= 1'b0;
            reload_reg  <= RELOAD_RST;
            compare_reg <= COMPARE_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_go_reg  <= div_go_next;
            reload_reg  <= reload_next;
            compare_reg <= compare_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and output data registers
    always_ff @(posedge aclk) begin
        pn_reg     <= pn_next;
        val_reg    <= val_next;
        ok_reg     <= ok_next;
        freq_reg   <= freq_next;
        duty_reg   <= duty_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
